// ----- rtl/dmfm_pkg.sv -----
// Shared types and constants for the disk MFM deserializer with sync DMA.
package dmfm_pkg;

  typedef enum logic [1:0] {
    MODE_CELL = 2'd0,
    MODE_LEN  = 2'd1,
    MODE_PTR  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_SYNC_WORD  = 2'd0,
    CFG_SYNC_EN    = 2'd1,
    CFG_DMA_EN     = 2'd2,
    CFG_RESERVED   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    DMA_IDLE   = 3'b001,
    DMA_ARMED  = 3'b010,
    DMA_ACTIVE = 3'b100
  } dma_phase_t;

  localparam int unsigned LEN_ARM_BIT   = 15;
  localparam logic [15:0] LEN_COUNT_MSK = 16'h3fff;
  localparam logic [31:0] PTR_STEP      = 32'd2;

endpackage

// ----- rtl/disk_mfm_deserializer_sync_dma.sv -----
// Floppy read deserializer: bit-cell shifter, sync-word detect and read DMA.
// A result is registered and shows on out_ the cycle after its item is taken.
// Throughput: one item per cycle; the input stays ready while the result register
//   is empty or being drained in the same cycle.
// Reset: synchronous on rst_n low; clears all but the result data registers.
// All per-item work is a shift, a 16-bit compare and counter updates in one stage.
module disk_mfm_deserializer_sync_dma (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic        in_cell_bit,
  input  logic        in_track_end,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_byte_status,
  output logic        out_dma_write_valid,
  output logic [31:0] out_dma_address,
  output logic [15:0] out_dma_data,
  output logic        out_sync_interrupt,
  output logic        out_block_done_interrupt,
  output logic        out_index_pulse,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dmfm_pkg::*;

  // configuration
  logic [15:0] sync_word_r;
  logic        sync_en_r;
  logic        dma_en_r;

  // deserializer and DMA state
  logic [15:0] shift_r,   shift_nxt;
  logic [3:0]  count_r,   count_nxt;
  logic [7:0]  byte_r,    byte_nxt;
  logic        ready_r,   ready_nxt;
  logic        equal_r,   equal_nxt;
  dma_phase_t  phase_r,   phase_nxt;
  logic [15:0] length_r,  length_nxt;
  logic [31:0] ptr_r,     ptr_nxt;

  // result register
  logic        out_valid_r;
  logic [15:0] status_r;
  logic        wr_valid_r, wr_valid_nxt;
  logic [31:0] wr_addr_r,  wr_addr_nxt;
  logic [15:0] wr_data_r,  wr_data_nxt;
  logic        sync_irq_r, sync_irq_nxt;
  logic        done_irq_r, done_irq_nxt;
  logic        index_r,    index_nxt;

  logic        accept;
  logic        match;
  logic [15:0] status_nxt;
  logic [15:0] len_write;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign len_write = in_write_value[15:0];
  assign match     = sync_en_r && (shift_nxt == sync_word_r);

  always_comb begin
    shift_nxt    = shift_r;
    count_nxt    = count_r;
    byte_nxt     = byte_r;
    ready_nxt    = ready_r;
    equal_nxt    = equal_r;
    phase_nxt    = phase_r;
    length_nxt   = length_r;
    ptr_nxt      = ptr_r;
    wr_valid_nxt = 1'b0;
    wr_addr_nxt  = '0;
    wr_data_nxt  = '0;
    sync_irq_nxt = 1'b0;
    done_irq_nxt = 1'b0;
    index_nxt    = 1'b0;
    unique case (mode_t'(in_mode))
      MODE_CELL: begin
        shift_nxt = {shift_r[14:0], in_cell_bit};
        index_nxt = in_track_end;
        count_nxt = count_r + 4'd1;
        equal_nxt = 1'b0;
        if (count_nxt[2:0] == 3'd0) begin
          ready_nxt = 1'b1;
          byte_nxt  = shift_nxt[7:0];
          // word boundary of an active transfer: write, then check for end of block
          if (phase_r == DMA_ACTIVE && count_nxt[3] == 1'b0) begin
            if ((length_r & LEN_COUNT_MSK) != '0) begin
              wr_valid_nxt = 1'b1;
              wr_addr_nxt  = ptr_r;
              wr_data_nxt  = shift_nxt;
              ptr_nxt      = ptr_r + PTR_STEP;
              length_nxt   = length_r - 16'd1;
            end
            if ((length_nxt & LEN_COUNT_MSK) == '0) begin
              phase_nxt    = DMA_IDLE;
              done_irq_nxt = 1'b1;
            end
          end
        end
        if (match) begin
          sync_irq_nxt = 1'b1;
          equal_nxt    = 1'b1;
          count_nxt    = '0;
          if (dma_en_r && phase_r == DMA_ARMED) begin
            phase_nxt = DMA_ACTIVE;
          end
        end
      end
      MODE_LEN: begin
        // two arm-bit writes in a row arm an idle transfer; one without it aborts
        priority if (length_r[LEN_ARM_BIT] && len_write[LEN_ARM_BIT] && phase_r == DMA_IDLE) begin
          phase_nxt = DMA_ARMED;
        end else if (!len_write[LEN_ARM_BIT] && phase_r != DMA_IDLE) begin
          phase_nxt = DMA_IDLE;
        end
        length_nxt = len_write;
      end
      MODE_PTR: begin
        ptr_nxt = in_write_value;
      end
      MODE_NONE: begin
      end
      default: begin
      end
    endcase
    status_nxt = {ready_nxt, 2'b00, equal_nxt, 4'b0000, byte_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= '0;
      sync_en_r   <= 1'b0;
      dma_en_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC_WORD: sync_word_r <= cfg_data;
        CFG_SYNC_EN:   sync_en_r   <= cfg_data[0];
        CFG_DMA_EN:    dma_en_r    <= cfg_data[0];
        CFG_RESERVED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '0;
      count_r  <= '0;
      byte_r   <= '0;
      ready_r  <= 1'b0;
      equal_r  <= 1'b0;
      phase_r  <= DMA_IDLE;
      length_r <= '0;
      ptr_r    <= '0;
    end else if (accept) begin
      shift_r  <= shift_nxt;
      count_r  <= count_nxt;
      byte_r   <= byte_nxt;
      ready_r  <= ready_nxt;
      equal_r  <= equal_nxt;
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      wr_valid_r <= wr_valid_nxt;
      wr_addr_r  <= wr_addr_nxt;
      wr_data_r  <= wr_data_nxt;
      sync_irq_r <= sync_irq_nxt;
      done_irq_r <= done_irq_nxt;
      index_r    <= index_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_byte_status          = status_r;
  assign out_dma_write_valid      = wr_valid_r;
  assign out_dma_address          = wr_addr_r;
  assign out_dma_data             = wr_data_r;
  assign out_sync_interrupt       = sync_irq_r;
  assign out_block_done_interrupt = done_irq_r;
  assign out_index_pulse          = index_r;

`ifndef ASSERT_OFF
  a_sync_sets_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sync_irq_r |-> status_r[12])
    else $error("sync interrupt without word-equal status");

  a_write_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    accept && wr_valid_nxt |=> length_r == $past(length_r) - 16'd1)
    else $error("DMA write did not decrement length");

  a_write_advances_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    accept && wr_valid_nxt |=> ptr_r == $past(ptr_r) + PTR_STEP)
    else $error("DMA write did not advance pointer");

  a_write_only_active: assert property (@(posedge clk) disable iff (!rst_n)
    accept && wr_valid_nxt |-> phase_r == DMA_ACTIVE)
    else $error("DMA write outside active transfer");

  a_ptr_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == MODE_PTR |=> ptr_r == $past(in_write_value))
    else $error("pointer write not taken");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the MFM deserializer with sync-word detection and read DMA.
`timescale 1ns / 100ps

module tb_top;
  import dmfm_pkg::*;

  typedef struct packed {
    logic [15:0] byte_status;
    logic        dma_write_valid;
    logic [31:0] dma_address;
    logic [15:0] dma_data;
    logic        sync_interrupt;
    logic        block_done_interrupt;
    logic        index_pulse;
  } mfm_result_t;

  class mfm_scoreboard;
    logic [15:0] sync_pat;
    logic        sync_en;
    logic        dma_en;
    logic [15:0] shift_w;
    logic [3:0]  bit_cnt;
    logic [7:0]  last_b;
    logic        byte_rdy;
    logic        word_eq;
    dma_phase_t  phase;
    logic [15:0] len_w;
    logic [31:0] ptr;
    mfm_result_t due_q[$];
    int          mismatches;

    function new();
      sync_pat = '0;
      sync_en = 1'b0;
      dma_en = 1'b0;
      shift_w = '0;
      bit_cnt = '0;
      last_b = '0;
      byte_rdy = 1'b0;
      word_eq = 1'b0;
      phase = DMA_IDLE;
      len_w = '0;
      ptr = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (cfg_idx_t'(idx))
        CFG_SYNC_WORD: sync_pat = data;
        CFG_SYNC_EN:   sync_en = data[0];
        CFG_DMA_EN:    dma_en = data[0];
        default: ;
      endcase
    endfunction

    function void take_item(logic [1:0] mode, logic cell_v, logic tend, logic [31:0] wval);
      mfm_result_t r;
      logic [15:0] nv;
      r = '0;
      case (mode_t'(mode))
        MODE_CELL: begin
          shift_w = {shift_w[14:0], cell_v};
          r.index_pulse = tend;
          bit_cnt = bit_cnt + 4'd1;
          word_eq = 1'b0;
          if (bit_cnt[2:0] == 3'd0) begin
            byte_rdy = 1'b1;
            last_b = shift_w[7:0];
            if (phase == DMA_ACTIVE && bit_cnt == 4'd0) begin
              if ((len_w & LEN_COUNT_MSK) != 16'd0) begin
                r.dma_write_valid = 1'b1;
                r.dma_address = ptr;
                r.dma_data = shift_w;
                ptr = ptr + PTR_STEP;
                len_w = len_w - 16'd1;
              end
              // stop at zero count, with or without a final write
              if ((len_w & LEN_COUNT_MSK) == 16'd0) begin
                phase = DMA_IDLE;
                r.block_done_interrupt = 1'b1;
              end
            end
          end
          if (sync_en && shift_w == sync_pat) begin
            r.sync_interrupt = 1'b1;
            word_eq = 1'b1;
            bit_cnt = 4'd0;
            if (dma_en && phase == DMA_ARMED)
              phase = DMA_ACTIVE;
          end
        end
        MODE_LEN: begin
          nv = wval[15:0];
          // arm on two writes in a row with the arm bit, abort on a write without it
          if (len_w[LEN_ARM_BIT] && nv[LEN_ARM_BIT] && phase == DMA_IDLE)
            phase = DMA_ARMED;
          else if (!nv[LEN_ARM_BIT] && phase != DMA_IDLE)
            phase = DMA_IDLE;
          len_w = nv;
        end
        MODE_PTR: ptr = wval;
        default: ;
      endcase
      r.byte_status = {byte_rdy, 2'b00, word_eq, 4'b0000, last_b};
      due_q.push_back(r);
    endfunction

    function void check_result(mfm_result_t got);
      mfm_result_t want;
      bit bad;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%h wr=%b addr=%h data=%h sync=%b done=%b idx=%b",
                   got.byte_status, got.dma_write_valid, got.dma_address, got.dma_data,
                   got.sync_interrupt, got.block_done_interrupt, got.index_pulse);
        return;
      end
      want = due_q.pop_front();
      bad = (got.byte_status !== want.byte_status) ||
            (got.dma_write_valid !== want.dma_write_valid) ||
            (got.dma_address !== want.dma_address) ||
            (got.dma_data !== want.dma_data) ||
            (got.sync_interrupt !== want.sync_interrupt) ||
            (got.block_done_interrupt !== want.block_done_interrupt) ||
            (got.index_pulse !== want.index_pulse);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: status=%h wr=%b addr=%h data=%h sync=%b done=%b idx=%b",
                   want.byte_status, want.dma_write_valid, want.dma_address, want.dma_data,
                   want.sync_interrupt, want.block_done_interrupt, want.index_pulse);
          $display("         got: status=%h wr=%b addr=%h data=%h sync=%b done=%b idx=%b",
                   got.byte_status, got.dma_write_valid, got.dma_address, got.dma_data,
                   got.sync_interrupt, got.block_done_interrupt, got.index_pulse);
        end
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic        in_cell_bit;
  logic        in_track_end;
  logic [31:0] in_write_value;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_byte_status;
  logic        out_dma_write_valid;
  logic [31:0] out_dma_address;
  logic [15:0] out_dma_data;
  logic        out_sync_interrupt;
  logic        out_block_done_interrupt;
  logic        out_index_pulse;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  mfm_scoreboard sb;
  logic [15:0]   cur_sync;
  bit            no_idle;
  bit            hold_req;
  int            phase_items;
  int            quiet_cycles;

  disk_mfm_deserializer_sync_dma DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_mode                  (in_mode),
    .in_cell_bit              (in_cell_bit),
    .in_track_end             (in_track_end),
    .in_write_value           (in_write_value),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_byte_status          (out_byte_status),
    .out_dma_write_valid      (out_dma_write_valid),
    .out_dma_address          (out_dma_address),
    .out_dma_data             (out_dma_data),
    .out_sync_interrupt       (out_sync_interrupt),
    .out_block_done_interrupt (out_block_done_interrupt),
    .out_index_pulse          (out_index_pulse),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check results before noting the new transaction; a result never belongs to an item
  // taken at the same edge.
  always @(posedge clk) begin
    mfm_result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.byte_status = out_byte_status;
        got.dma_write_valid = out_dma_write_valid;
        got.dma_address = out_dma_address;
        got.dma_data = out_dma_data;
        got.sync_interrupt = out_sync_interrupt;
        got.block_done_interrupt = out_block_done_interrupt;
        got.index_pulse = out_index_pulse;
        sb.check_result(got);
      end
      if (in_valid && in_ready)
        sb.take_item(in_mode, in_cell_bit, in_track_end, in_write_value);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Result side: one assignment per falling edge; long hold on request, random stalls.
  // The long hold starts once the sender is offering and a result is waiting.
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done && in_valid && out_valid) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Enter and leave at a falling edge; valid stays high until the caller drives again.
  task automatic send_item(logic [1:0] mode, logic cell_v, logic tend, logic [31:0] wval);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_cell_bit <= cell_v;
    in_track_end <= tend;
    in_write_value <= wval;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    phase_items++;
  endtask

  function automatic logic rand_tend();
    return ($urandom_range(0, 19) == 0);
  endfunction

  task automatic send_cell(logic cell_v, logic tend);
    send_item(MODE_CELL, cell_v, tend, $urandom());
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_config(logic [15:0] pattern, logic sen, logic den);
    cur_sync = pattern;
    write_reg(CFG_SYNC_WORD, pattern);
    write_reg(CFG_SYNC_EN, {15'($urandom()), sen});
    write_reg(CFG_DMA_EN, {15'($urandom()), den});
    cfg_valid <= 1'b0;
  endtask

  // Pointer, two arming length writes, leading cells, sync word, data; may abort.
  task automatic read_sector(logic [31:0] start, int unsigned words);
    logic [15:0] lw;
    int unsigned n_data;
    int unsigned abort_at;
    lw = {1'b1, 1'($urandom_range(0, 1)), 14'(words)};
    send_item(MODE_PTR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), start);
    send_item(MODE_LEN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              {16'($urandom()), lw});
    send_item(MODE_LEN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              {16'($urandom()), lw});
    repeat ($urandom_range(0, 20)) send_cell(1'($urandom_range(0, 1)), rand_tend());
    for (int i = 15; i >= 0; i--)
      send_cell(cur_sync[i], rand_tend());
    n_data = 16 * (words + 1);
    abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_data - 1) : n_data;
    for (int unsigned i = 0; i < n_data; i++) begin
      if (i == abort_at)
        send_item(MODE_LEN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  {16'($urandom()), 1'b0, 15'($urandom())});
      send_cell(1'($urandom_range(0, 1)), rand_tend());
    end
  endtask

  function automatic logic [31:0] pick_start();
    case ($urandom_range(0, 3))
      0:       return 32'hffff_ffff - 32'($urandom_range(0, 1));
      1:       return $urandom();
      2:       return $urandom() | 32'd1;
      default: return $urandom() & ~32'd1;
    endcase
  endfunction

  task automatic run_phase(logic [15:0] pattern, logic sen, logic den, int n_items, bit lead);
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    load_config(pattern, sen, den);
    phase_items = 0;
    if (lead) begin
      read_sector(32'hffff_ffff, 1);
      read_sector($urandom(), 0);
    end
    while (phase_items < n_items) begin
      if ($urandom_range(0, 4) == 0)
        send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom());
      else
        read_sector(pick_start(), ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_CELL;
    in_cell_bit = 1'b0;
    in_track_end = 1'b0;
    in_write_value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SYNC_WORD;
    cfg_data = '0;
    cur_sync = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    phase_items = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: unused mode, pointer and length extremes, arm then abort, byte latching.
    send_item(MODE_NONE, 1'b1, 1'b1, 32'hffff_ffff);
    send_item(MODE_PTR, 1'b0, 1'b0, 32'hffff_ffff);
    send_item(MODE_PTR, 1'b1, 1'b1, 32'h0000_0000);
    send_item(MODE_LEN, 1'b0, 1'b0, 32'hffff_ffff);
    send_item(MODE_LEN, 1'b0, 1'b0, 32'h0000_ffff);
    send_item(MODE_NONE, 1'b0, 1'b0, 32'h0000_0000);
    send_item(MODE_LEN, 1'b1, 1'b1, 32'hffff_7fff);
    repeat (7) send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    send_cell(1'b0, 1'b1);
    repeat (7) send_cell(1'b0, 1'b0);
    in_valid <= 1'b0;

    run_phase(16'h4489, 1'b1, 1'b1, 60, 1'b1);
    hold_req = 1'b1;
    run_phase(16'hffff, 1'b1, 1'b1, 60, 1'b0);
    run_phase(16'($urandom()), 1'b0, 1'b1, 60, 1'b0);
    run_phase(16'($urandom()), 1'b1, 1'b0, 60, 1'b0);
    run_phase(16'h0000, 1'b1, 1'b1, 60, 1'b1);
    no_idle = 1'b1;
    run_phase(16'($urandom()), 1'b1, 1'b1, 60, 1'b0);

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
